// ----- rtl/core/sbl_pkg.sv -----
package sbl_pkg;

  localparam int SBL_DEPTH = 16;
  localparam int SBL_VAL_W = 8;
  localparam int SBL_CNT_W = 5;

  typedef enum logic [0:0] {
    FN_INSERT = 1'b0,
    FN_DELETE = 1'b1
  } sbl_func_t;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_FULL      = 2'd1,
    ST_DELETED   = 2'd2,
    ST_NOT_FOUND = 2'd3
  } sbl_status_t;

  typedef struct packed {
    logic [0:0]           func;
    logic [SBL_VAL_W-1:0] value;
  } sbl_in_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [SBL_CNT_W-1:0] count;
    logic                 empty_res;
    logic [SBL_VAL_W-1:0] smallest;
  } sbl_out_t;

  // Operation broadcast to every cell of the chain.
  typedef struct packed {
    logic                 ins;
    logic                 del;
    logic [SBL_VAL_W-1:0] value;
  } sbl_cmd_t;

  // What a cell shows its neighbors.
  typedef struct packed {
    logic                 stay;
    logic                 valid;
    logic [SBL_VAL_W-1:0] value;
  } sbl_link_t;

endpackage

// ----- rtl/core/sbl_cell.sv -----
module sbl_cell
  import sbl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  sbl_cmd_t  cmd,
  input  sbl_link_t left_in,
  input  sbl_link_t right_in,
  output sbl_link_t link_out,
  output logic      match
);

  logic                 valid_r, valid_nxt;
  logic [SBL_VAL_W-1:0] value_r, value_nxt;
  logic                 stay;
  logic                 ge;

  // An entry not above the new value keeps its place on insert.
  assign stay  = valid_r && (value_r <= cmd.value);
  assign ge    = valid_r && (value_r >= cmd.value);
  assign match = valid_r && (value_r == cmd.value);

  assign link_out.stay  = stay;
  assign link_out.valid = valid_r;
  assign link_out.value = value_r;

  always_comb begin
    valid_nxt = valid_r;
    value_nxt = value_r;
    if (cmd.ins && !stay) begin
      if (left_in.stay) begin
        valid_nxt = 1'b1;
        value_nxt = cmd.value;
      end else begin
        valid_nxt = left_in.valid;
        value_nxt = left_in.value;
      end
    end else if (cmd.del && ge) begin
      // Everything from the first equal entry onward moves one place toward the head.
      valid_nxt = right_in.valid;
      value_nxt = right_in.value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule

// ----- rtl/core/sorted_byte_list.sv -----
// Sorted list of up to DEPTH bytes held in a chain of compare-and-shift cells.
// The result of an operation is registered and presented in the cycle after its transfer.
// Throughput: one operation per cycle while the result side does not stall; every cell updates in the same cycle.
// Reset (synchronous, active low) marks all cells empty and clears the count;
// no clearing pass is needed, so operations are taken right after reset.
module sorted_byte_list
  import sbl_pkg::*;
#(
  parameter int DEPTH = SBL_DEPTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  sbl_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output sbl_out_t out_data
);

  localparam int CntW = $clog2(DEPTH + 1);

  sbl_cmd_t             cmd;
  sbl_link_t            links [DEPTH];
  sbl_link_t            left_tie;
  sbl_link_t            right_tie;
  logic [DEPTH-1:0]     hit_vec;
  logic                 found;
  logic                 full;
  logic                 in_xfer;
  logic                 is_ins;
  logic                 out_valid_r, out_valid_nxt;
  logic [CntW-1:0]      count_r, count_nxt;
  sbl_status_t          status_r, status_nxt;

  // The head sees an entry that stays in front of it, so an insert lands there.
  assign left_tie  = '{stay: 1'b1, valid: 1'b0, value: '0};
  assign right_tie = '{stay: 1'b0, valid: 1'b0, value: '0};

  assign in_ready = !out_valid_r || out_ready;
  assign in_xfer  = in_valid && in_ready;
  assign is_ins   = (sbl_func_t'(in_data.func) == FN_INSERT);
  assign full     = (count_r == CntW'(DEPTH));
  assign found    = |hit_vec;

  assign cmd.ins   = in_xfer && is_ins && !full;
  assign cmd.del   = in_xfer && !is_ins && found;
  assign cmd.value = in_data.value;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    sbl_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd      (cmd),
      .left_in  ((i == 0) ? left_tie : links[(i == 0) ? 0 : i - 1]),
      .right_in ((i == DEPTH - 1) ? right_tie : links[(i == DEPTH - 1) ? i : i + 1]),
      .link_out (links[i]),
      .match    (hit_vec[i])
    );
  end

  always_comb begin
    count_nxt     = count_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_xfer) begin
      out_valid_nxt = 1'b1;
      if (is_ins) begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          status_nxt = ST_INSERTED;
          count_nxt  = count_r + 1'b1;
        end
      end else begin
        if (found) begin
          status_nxt = ST_DELETED;
          count_nxt  = count_r - 1'b1;
        end else begin
          status_nxt = ST_NOT_FOUND;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      count_r     <= '0;
      status_r    <= ST_INSERTED;
    end else begin
      out_valid_r <= out_valid_nxt;
      count_r     <= count_nxt;
      status_r    <= status_nxt;
    end
  end

  // The result reads the cell chain directly, which already holds the updated list.
  assign out_valid          = out_valid_r;
  assign out_data.status    = status_r;
  assign out_data.count     = SBL_CNT_W'(count_r);
  assign out_data.empty_res = !links[0].valid;
  assign out_data.smallest  = links[0].valid ? links[0].value : '0;

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
  import sbl_pkg::*;

  localparam int NUM_RANDOM_OPS = 1500;
  localparam int CYCLE_LIMIT    = 400000;

  // Shadow of the sorted list plus the queue of results still owed by the block.
  class list_scoreboard;
    logic [SBL_VAL_W-1:0] held[$];
    sbl_out_t             owed_q[$];
    int                   mismatches;
    int                   status_seen[4];
    int                   deepest;
    int                   empties;

    function int pending();
      return owed_q.size();
    endfunction

    function void note_input(sbl_in_t op);
      sbl_out_t owed;
      int       pos;
      int       i;
      pos = 0;
      if (op.func == FN_INSERT) begin
        if (held.size() >= SBL_DEPTH) begin
          owed.status = ST_FULL;
        end else begin
          while (pos < held.size() && held[pos] <= op.value) pos++;
          held.push_back(op.value);
          for (i = held.size() - 1; i > pos; i--) held[i] = held[i - 1];
          held[pos] = op.value;
          owed.status = ST_INSERTED;
        end
      end else begin
        while (pos < held.size() && held[pos] != op.value) pos++;
        if (pos >= held.size()) begin
          owed.status = ST_NOT_FOUND;
        end else begin
          for (i = pos; i + 1 < held.size(); i++) held[i] = held[i + 1];
          void'(held.pop_back());
          owed.status = ST_DELETED;
        end
      end
      owed.count     = SBL_CNT_W'(held.size());
      owed.empty_res = (held.size() == 0);
      owed.smallest  = (held.size() == 0) ? '0 : held[0];
      owed_q.push_back(owed);
    endfunction

    function void check_result(sbl_out_t got);
      sbl_out_t want;
      if (owed_q.size() == 0) begin
        $display("%0t: result %h arrived with no operation outstanding", $time, got);
        mismatches++;
        return;
      end
      want = owed_q.pop_front();
      if (got.status != want.status) begin
        $display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
        mismatches++;
      end
      if (got.count != want.count) begin
        $display("%0t: count expected %0d, got %0d", $time, want.count, got.count);
        mismatches++;
      end
      if (got.empty_res != want.empty_res) begin
        $display("%0t: empty flag expected %0b, got %0b", $time, want.empty_res,
                 got.empty_res);
        mismatches++;
      end
      if (got.smallest != want.smallest) begin
        $display("%0t: smallest expected %h, got %h", $time, want.smallest, got.smallest);
        mismatches++;
      end
      status_seen[want.status]++;
      if (want.count > deepest) deepest = want.count;
      if (want.empty_res) empties++;
    endfunction
  endclass

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  sbl_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  sbl_out_t out_data;

  bit in_burst  = 1'b0;
  bit out_burst = 1'b0;
  int cycles    = 0;

  list_scoreboard sb = new();

  sorted_byte_list dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d results outstanding.", cycles,
               sb.pending());
      $display("testbench failed");
      $finish;
    end
    // Note the operation before checking, so a same-edge result would still find it.
    if (rst_n && in_valid && in_ready) sb.note_input(in_data);
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  // Result side: a random stall before each transfer, none in burst stretches.
  initial begin
    int stall;
    forever begin
      stall = out_burst ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  task automatic send_op(input sbl_func_t f, input logic [SBL_VAL_W-1:0] v);
    sbl_in_t op;
    int      gap;
    op.func  = f;
    op.value = v;
    gap = in_burst ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= op;
    do @(posedge clk); while (!(in_valid && in_ready));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int                   n;
    int                   i;
    int                   insert_pct;
    bit                   narrow;
    sbl_func_t            f;
    logic [SBL_VAL_W-1:0] v;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty list cases, both ends of the byte range, equal values and a miss.
    send_op(FN_DELETE, 8'h00);
    send_op(FN_INSERT, 8'hFF);
    send_op(FN_INSERT, 8'h00);
    send_op(FN_INSERT, 8'h00);
    send_op(FN_DELETE, 8'hFF);
    send_op(FN_DELETE, 8'h4D);
    send_op(FN_DELETE, 8'h00);
    send_op(FN_DELETE, 8'h00);
    // Fill in descending order so every insert lands at the head, then overflow.
    for (i = 0; i < SBL_DEPTH; i++) send_op(FN_INSERT, SBL_VAL_W'((15 - i) * 17));
    send_op(FN_INSERT, 8'h80);
    drain();

    insert_pct = 50;
    narrow     = 1'b0;
    for (n = 0; n < NUM_RANDOM_OPS; n++) begin
      if (n % 250 == 0) begin
        in_burst  = ($urandom_range(0, 3) == 0);
        out_burst = ($urandom_range(0, 3) == 0);
        case ($urandom_range(0, 2))
          0: insert_pct = 30;
          1: insert_pct = 50;
          default: insert_pct = 70;
        endcase
        narrow = ($urandom_range(0, 2) == 0);
      end
      if (n == NUM_RANDOM_OPS / 2) drain();
      f = ($urandom_range(0, 99) < insert_pct) ? FN_INSERT : FN_DELETE;
      v = narrow ? SBL_VAL_W'($urandom_range(0, 7)) : SBL_VAL_W'($urandom_range(0, 255));
      // Most deletes aim at a value that is held, so the list keeps moving.
      if (f == FN_DELETE && sb.held.size() > 0 && $urandom_range(0, 3) != 0)
        v = sb.held[$urandom_range(0, sb.held.size() - 1)];
      send_op(f, v);
    end

    drain();
    repeat (4) @(posedge clk);

    $display("Checked %0d inserts, %0d refused as full, %0d deletes, %0d misses.",
             sb.status_seen[ST_INSERTED], sb.status_seen[ST_FULL],
             sb.status_seen[ST_DELETED], sb.status_seen[ST_NOT_FOUND]);
    $display("Fill reached %0d entries; the list was left empty %0d times; %0d mismatches.",
             sb.deepest, sb.empties, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/sbl_pkg.sv
rtl/core/sbl_cell.sv
rtl/core/sorted_byte_list.sv
tb/sv/testbench.sv
